/* rtl/mde_pkg.sv */
package mde_pkg;

    // Major opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_XORI    = 6'h0e;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2b;

    // SPECIAL function codes
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0c;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2a;
    localparam logic [5:0] FN_SLTU    = 6'h2b;

    localparam logic [31:0] HALT_CODE = 32'd10;
    localparam logic [4:0]  LINK_REG  = 5'd31;

    typedef enum logic [3:0] {
        MEM_NONE = 4'd0,
        MEM_LW   = 4'd1,
        MEM_LH   = 4'd2,
        MEM_LHU  = 4'd3,
        MEM_LB   = 4'd4,
        MEM_LBU  = 4'd5,
        MEM_SW   = 4'd6,
        MEM_SH   = 4'd7,
        MEM_SB   = 4'd8
    } mem_kind_t;

    typedef struct packed {
        logic [31:0] v0_value;
        logic [31:0] rt_value;
        logic [31:0] rs_value;
        logic [31:0] fetch_address;
        logic [31:0] instruction;
    } mde_in_t;

    typedef struct packed {
        logic        invalid_instr;
        logic        halt_request;
        logic [31:0] jump_target;
        logic        take_jump;
        mem_kind_t   mem_kind;
        logic        reg_write;
        logic [4:0]  dest_reg;
        logic [31:0] store_data;
        logic [31:0] result_value;
    } mde_out_t;

    function automatic logic slt_signed(input logic [31:0] a, input logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // Decode and execute one instruction word
    function automatic mde_out_t mde_execute(input mde_in_t x);
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [4:0]  vs;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm;
        logic [31:0] sext;
        logic [31:0] next_pc;
        logic [31:0] addr;
        logic        bad;
        mde_out_t    r;

        op      = x.instruction[31:26];
        fn      = x.instruction[5:0];
        rt      = x.instruction[20:16];
        rd      = x.instruction[15:11];
        sh      = x.instruction[10:6];
        a       = x.rs_value;
        b       = x.rt_value;
        vs      = a[4:0];
        imm     = {16'h0000, x.instruction[15:0]};
        sext    = {{16{x.instruction[15]}}, x.instruction[15:0]};
        next_pc = x.fetch_address + 32'd4;
        addr    = a + sext;
        bad     = 1'b0;
        r       = '0;

        unique case (op)
            OP_SPECIAL:
            begin
                r.reg_write = 1'b1;
                r.dest_reg  = rd;
                unique case (fn)
                    FN_SLL:  r.result_value = b << sh;
                    FN_SRL:  r.result_value = b >> sh;
                    FN_SRA:  r.result_value = 32'($signed(b) >>> sh);
                    FN_SLLV: r.result_value = b << vs;
                    FN_SRLV: r.result_value = b >> vs;
                    FN_SRAV: r.result_value = 32'($signed(b) >>> vs);
                    FN_JR:
                    begin
                        r.reg_write   = 1'b0;
                        r.dest_reg    = '0;
                        r.take_jump   = 1'b1;
                        r.jump_target = a;
                    end
                    FN_JALR:
                    begin
                        r.take_jump    = 1'b1;
                        r.jump_target  = a;
                        r.result_value = next_pc;
                    end
                    FN_SYSCALL:
                    begin
                        r.reg_write    = 1'b0;
                        r.dest_reg     = '0;
                        r.halt_request = (x.v0_value == HALT_CODE);
                    end
                    FN_ADD, FN_ADDU: r.result_value = a + b;
                    FN_SUB, FN_SUBU: r.result_value = a - b;
                    FN_AND:  r.result_value = a & b;
                    FN_OR:   r.result_value = a | b;
                    FN_XOR:  r.result_value = a ^ b;
                    FN_NOR:  r.result_value = ~(a | b);
                    FN_SLT:  r.result_value = {31'd0, slt_signed(a, b)};
                    FN_SLTU: r.result_value = {31'd0, (a < b)};
                    default: bad = 1'b1;
                endcase
            end
            OP_J, OP_JAL:
            begin
                r.take_jump   = 1'b1;
                r.jump_target = {next_pc[31:28], x.instruction[25:0], 2'b00};
                if (op == OP_JAL)
                begin
                    r.reg_write    = 1'b1;
                    r.dest_reg     = LINK_REG;
                    r.result_value = next_pc;
                end
            end
            OP_BEQ, OP_BNE:
            begin
                if ((op == OP_BEQ) == (a == b))
                begin
                    r.take_jump   = 1'b1;
                    r.jump_target = next_pc + {sext[29:0], 2'b00};
                end
            end
            OP_ADDI, OP_ADDIU:
            begin
                r.reg_write    = 1'b1;
                r.dest_reg     = rt;
                r.result_value = addr;
            end
            OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI:
            begin
                r.reg_write = 1'b1;
                r.dest_reg  = rt;
                unique case (op)
                    OP_SLTI:  r.result_value = {31'd0, slt_signed(a, sext)};
                    OP_SLTIU: r.result_value = {31'd0, (a < sext)};
                    OP_ANDI:  r.result_value = a & imm;
                    OP_ORI:   r.result_value = a | imm;
                    OP_XORI:  r.result_value = a ^ imm;
                    default:  r.result_value = {imm[15:0], 16'h0000};
                endcase
            end
            OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU:
            begin
                r.reg_write    = 1'b1;
                r.dest_reg     = rt;
                r.result_value = addr;
                unique case (op)
                    OP_LW:   r.mem_kind = MEM_LW;
                    OP_LH:   r.mem_kind = MEM_LH;
                    OP_LHU:  r.mem_kind = MEM_LHU;
                    OP_LB:   r.mem_kind = MEM_LB;
                    default: r.mem_kind = MEM_LBU;
                endcase
            end
            OP_SW, OP_SH, OP_SB:
            begin
                r.result_value = addr;
                r.store_data   = b;
                unique case (op)
                    OP_SW:   r.mem_kind = MEM_SW;
                    OP_SH:   r.mem_kind = MEM_SH;
                    default: r.mem_kind = MEM_SB;
                endcase
            end
            default: bad = 1'b1;
        endcase

        if (bad)
        begin
            r               = '0;
            r.invalid_instr = 1'b1;
        end
        return r;
    endfunction

endpackage

/* rtl/mips_decode_execute.sv */
// MIPS32 integer-subset decode and execute. Each input word carries one
// instruction with its fetch address and the rs, rt and v0 register values;
// each output word carries the ALU result (or load/store address, or link
// address), store data, destination register and write enable, memory
// operation kind, jump flag and target, halt request (syscall with v0 == 10)
// and an invalid flag, with every other field zero when invalid. Branch and
// jump targets are resolved here. The block takes one word per clock and
// gives one word per clock while m_tready is held high; a word accepted
// into the input register passes the combinational decode/ALU path into the
// result register, where it shows as m_tvalid. The result register lets a new
// word enter while a finished one waits on m_tready.
module mips_decode_execute
    import mde_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] instruction, [63:32] fetch_address, [95:64] rs_value,
    // [127:96] rt_value, [159:128] v0_value
    input  logic [159:0] s_tdata,

    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] result_value, [63:32] store_data, [68:64] dest_reg,
    // [69] reg_write, [70] take_jump, [102:71] jump_target, [103] halt_request
    output logic [103:0] m_tdata,
    // [3:0] mem_kind, [4] invalid_instr, [7:5] zero
    output logic [7:0]   m_tuser
);

    logic     in_valid_reg;
    logic     in_valid_next;
    mde_in_t  in_word_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    mde_out_t out_word_reg;
    mde_out_t exec_word;
    logic     s_accept;
    logic     out_load;

    // Stage 1 -> stage 2 moves when the result register is empty or draining
    assign out_load  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || out_load;
    assign s_accept  = s_tvalid && s_tready;

    assign exec_word = mde_execute(in_word_reg);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (out_load)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
            in_word_reg <= mde_in_t'(s_tdata);
        if (out_load)
            out_word_reg <= exec_word;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_word_reg.halt_request,
                       out_word_reg.jump_target,
                       out_word_reg.take_jump,
                       out_word_reg.reg_write,
                       out_word_reg.dest_reg,
                       out_word_reg.store_data,
                       out_word_reg.result_value};
    assign m_tuser  = {3'b000, out_word_reg.invalid_instr, out_word_reg.mem_kind};

`ifndef ASSERT_OFF
    // An invalid instruction leaves every other field clear
    a_invalid_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[4]) |-> (m_tdata == '0 && m_tuser[3:0] == MEM_NONE))
        else $error("invalid word carries nonzero fields");

    // No jump means a zero target
    a_target_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[70]) |-> (m_tdata[102:71] == 32'd0))
        else $error("jump target set without a jump");

    // No register write means a zero destination
    a_dest_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[69]) |-> (m_tdata[68:64] == 5'd0))
        else $error("destination set without a register write");

    // A word moving out of stage 1 reaches the result register on the next edge
    a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid)
        else $error("result register missed a loaded word");
`endif

endmodule
